// ===== src/hfd_pkg.sv =====
// Shared types and constants for the HSMS frame deframer.
package hfd_pkg;

  // Result kinds carried on tuser
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_BODY   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_SHORT_LENGTH = 2'd0;
  localparam logic [1:0] ERR_LONG_LENGTH  = 2'd1;
  localparam logic [1:0] ERR_PROTO_TYPE   = 2'd2;

  // Frame layout
  localparam logic [31:0] HEADER_LEN        = 32'd10;
  localparam logic [3:0]  LENGTH_LAST_INDEX = 4'd3;
  localparam logic [3:0]  HEADER_LAST_INDEX = 4'd9;
  localparam int          HEADER_BITS       = 80;

  // Reset value of the maximum length register
  localparam logic [31:0] MAX_LENGTH_RESET = 32'd16777216;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Output data width: 82 field bits padded to whole bytes
  localparam int OUT_DATA_W = 88;

  // Receive phase, one-hot
  typedef enum logic [4:0] {
    PH_LENGTH = 5'b00001,
    PH_HEADER = 5'b00010,
    PH_BODY   = 5'b00100,
    PH_SKIP   = 5'b01000,
    PH_HALT   = 5'b10000
  } phase_t;

  // Command handed from front to back; body byte sits in payload[7:0],
  // header bytes 0..9 sit from payload[79:72] downward.
  typedef struct packed {
    logic [1:0]             kind;
    logic [1:0]             code;
    logic                   last;
    logic [HEADER_BITS-1:0] payload;
  } cmd_t;

  // Push side of the command queue
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } push_t;

endpackage

// ===== src/hsms_frame_deframer_unit.sv =====
// HSMS frame deframer top level: stream ports, configuration port, front, queue and back.
//
// Takes one byte of a received HSMS stream per cycle and emits header, body-byte and
// error results. Bytes are accepted back to back at one per cycle while the queue has
// room. Each result is registered in the command queue and then in the output register.
// The four-entry queue and the output register absorb downstream stalls, so input keeps
// flowing until the queue fills.
// A length field below 10 or above max_payload_length gives one error result and the
// block then drops all bytes until reset. The maximum register is written through the
// cfg channel, which is always ready, and takes effect at the next length check.
module hsms_frame_deframer_unit
  import hfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration write channel: max_payload_length
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [31:0]           cfg_data,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
  // output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [1:0] err_code, [17:2] sess_id, [25:18] header_byte_two,
  // [33:26] header_byte_three, [41:34] session_type, [73:42] system_tag,
  // [81:74] body_byte, [87:82] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic [1:0]            m_axis_tuser,   // [1:0] kind
  output logic                  m_axis_tlast    // last
);

  push_t push;
  logic  queue_full;
  logic  pop_valid;
  logic  pop_ready;
  cmd_t  pop_cmd;

  assign cfg_ready = 1'b1;

  hfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_valid   (s_axis_tvalid),
    .in_byte    (s_axis_tdata),
    .in_ready   (s_axis_tready),
    .queue_full (queue_full),
    .push       (push)
  );

  hfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (queue_full),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd)
  );

  hfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd       (pop_cmd),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_kind  (m_axis_tuser),
    .out_last  (m_axis_tlast),
    .out_data  (m_axis_tdata)
  );

endmodule

// ===== src/hfd_front.sv =====
// Front end: accepts stream bytes, tracks framing and classifies results.
module hfd_front
  import hfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic [7:0]  in_byte,
  output logic        in_ready,
  input  logic        queue_full,
  output push_t       push
);

  phase_t                 phase, phase_next;
  logic [3:0]             byte_index, byte_index_next;
  logic [31:0]            frame_length, frame_length_next;
  logic [31:0]            body_remaining, body_remaining_next;
  logic [HEADER_BITS-1:0] header_store;
  logic [31:0]            max_payload_length;
  logic                   accept;
  logic [31:0]            length_shift;
  logic [HEADER_BITS-1:0] header_full;
  logic [31:0]            remaining_dec;

  assign in_ready     = !queue_full;
  assign accept       = in_valid && in_ready;
  assign length_shift = {frame_length[23:0], in_byte};
  assign header_full  = {header_store[HEADER_BITS-9:0], in_byte};
  assign remaining_dec = (body_remaining != 32'd0) ? body_remaining - 32'd1 : 32'd0;

  // Decide next framing state and the command to queue
  always_comb begin
    phase_next          = phase;
    byte_index_next     = byte_index;
    frame_length_next   = frame_length;
    body_remaining_next = body_remaining;
    push                = '0;
    if (accept) begin
      unique case (phase)
        PH_LENGTH: begin
          frame_length_next = length_shift;
          byte_index_next   = byte_index + 4'd1;
          if (byte_index == LENGTH_LAST_INDEX) begin
            byte_index_next = 4'd0;
            if (length_shift < HEADER_LEN) begin
              push.valid    = 1'b1;
              push.cmd.kind = KIND_ERROR;
              push.cmd.code = ERR_SHORT_LENGTH;
              push.cmd.last = 1'b1;
              phase_next    = PH_HALT;
            end else if (length_shift > max_payload_length) begin
              push.valid    = 1'b1;
              push.cmd.kind = KIND_ERROR;
              push.cmd.code = ERR_LONG_LENGTH;
              push.cmd.last = 1'b1;
              phase_next    = PH_HALT;
            end else begin
              body_remaining_next = length_shift - HEADER_LEN;
              phase_next          = PH_HEADER;
            end
          end
        end
        PH_HEADER: begin
          byte_index_next = byte_index + 4'd1;
          if (byte_index == HEADER_LAST_INDEX) begin
            byte_index_next   = 4'd0;
            frame_length_next = 32'd0;
            push.valid        = 1'b1;
            if (header_full[47:40] != 8'd0) begin
              push.cmd.kind = KIND_ERROR;
              push.cmd.code = ERR_PROTO_TYPE;
              push.cmd.last = 1'b1;
              phase_next    = (body_remaining != 32'd0) ? PH_SKIP : PH_LENGTH;
            end else begin
              push.cmd.kind    = KIND_HEADER;
              push.cmd.payload = header_full;
              push.cmd.last    = (body_remaining == 32'd0);
              phase_next       = (body_remaining != 32'd0) ? PH_BODY : PH_LENGTH;
            end
          end
        end
        PH_BODY: begin
          push.valid               = 1'b1;
          push.cmd.kind            = KIND_BODY;
          push.cmd.payload[7:0]    = in_byte;
          push.cmd.last            = (remaining_dec == 32'd0);
          body_remaining_next      = remaining_dec;
          if (remaining_dec == 32'd0) begin
            phase_next = PH_LENGTH;
          end
        end
        PH_SKIP: begin
          body_remaining_next = remaining_dec;
          if (remaining_dec == 32'd0) begin
            phase_next = PH_LENGTH;
          end
        end
        PH_HALT: begin
          // drop every byte until reset
        end
        default: begin
          phase_next = PH_HALT;
        end
      endcase
    end
  end

  // Advance framing state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_LENGTH;
      byte_index     <= 4'd0;
      frame_length   <= 32'd0;
      body_remaining <= 32'd0;
    end else begin
      phase          <= phase_next;
      byte_index     <= byte_index_next;
      frame_length   <= frame_length_next;
      body_remaining <= body_remaining_next;
    end
  end

  // Shift header bytes in, first byte ends up on top
  always_ff @(posedge clk) begin
    if (accept && phase == PH_HEADER) begin
      header_store <= header_full;
    end
  end

  // Hold the maximum length register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_length <= MAX_LENGTH_RESET;
    end else if (cfg_valid) begin
      max_payload_length <= cfg_data;
    end
  end

endmodule

// ===== src/hfd_queue.sv =====
// Short command queue that decouples the front end from the output stage.
module hfd_queue
  import hfd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  full,
  output logic  pop_valid,
  input  logic  pop_ready,
  output cmd_t  pop_cmd
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_cmd   = entries[rd_ptr];
  assign do_push   = push.valid && !full;
  assign do_pop    = pop_valid && pop_ready;

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.cmd;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== src/hfd_back.sv =====
// Back end: unpacks queued commands into result fields in an output register.
module hfd_back
  import hfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  cmd_t                  cmd,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_kind,
  output logic                  out_last,
  output logic [OUT_DATA_W-1:0] out_data
);

  logic [OUT_DATA_W-1:0] data_next;
  logic                  is_header;
  logic                  is_body;
  logic                  is_error;

  assign cmd_ready = !out_valid || out_ready;
  assign is_header = (cmd.kind == KIND_HEADER);
  assign is_body   = (cmd.kind == KIND_BODY);
  assign is_error  = (cmd.kind == KIND_ERROR);

  // Format result fields, zero where the kind does not use them
  always_comb begin
    data_next = '0;
    if (is_error) begin
      data_next[1:0] = cmd.code;
    end
    if (is_header) begin
      data_next[17:2]  = cmd.payload[79:64];
      data_next[25:18] = cmd.payload[63:56];
      data_next[33:26] = cmd.payload[55:48];
      data_next[41:34] = cmd.payload[39:32];
      data_next[73:42] = cmd.payload[31:0];
    end
    if (is_body) begin
      data_next[81:74] = cmd.payload[7:0];
    end
  end

  // Load the output register when it is free or being taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_ready) begin
      out_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ready && cmd_valid) begin
      out_kind <= cmd.kind;
      out_last <= cmd.last;
      out_data <= data_next;
    end
  end

endmodule

// ===== dv/hsms_frame_deframer_unit_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the HSMS deframer: predicts results from accepted bytes, checks the output.
module hsms_frame_deframer_unit_checker
  import hfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [31:0]           cfg_data,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [1:0] err_code, [17:2] sess_id, [25:18] header_byte_two,
  // [33:26] header_byte_three, [41:34] session_type, [73:42] system_tag,
  // [81:74] body_byte, [87:82] zero
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic [1:0]            m_axis_tuser,   // [1:0] kind
  input  logic                  m_axis_tlast,
  output int                    mismatch_count,
  output int                    pending_count
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  code;
    logic [15:0] sess_id;
    logic [7:0]  byte_two;
    logic [7:0]  byte_three;
    logic [7:0]  session_type;
    logic [31:0] system_tag;
    logic [7:0]  body_byte;
    logic        last;
    logic [5:0]  pad;
  } deframe_result_t;

  // Shadow of the receive state
  phase_t          rx_phase;
  logic [3:0]      byte_cnt;
  logic [31:0]     length_acc;
  logic [31:0]     body_left;
  logic [31:0]     max_length;
  logic [7:0]      hdr_bytes [10];
  deframe_result_t expected_results [$];

  function automatic string describe(input deframe_result_t r);
    return $sformatf({"kind=%0d code=%0d sid=%h b2=%h b3=%h stype=%h tag=%h body=%h ",
                      "last=%b pad=%h"}, r.kind, r.code, r.sess_id, r.byte_two,
                     r.byte_three, r.session_type, r.system_tag, r.body_byte, r.last, r.pad);
  endfunction

  // Advance the shadow state by one stream byte, queue any result it causes
  task automatic deframe_byte(input logic [7:0] b);
    deframe_result_t r;
    logic            emit;
    r    = '0;
    emit = 1'b0;
    case (rx_phase)
      PH_LENGTH: begin
        length_acc = {length_acc[23:0], b};
        if (byte_cnt != LENGTH_LAST_INDEX) begin
          byte_cnt++;
        end else begin
          byte_cnt = '0;
          if (length_acc < HEADER_LEN || length_acc > max_length) begin
            // stream cannot resync: one error, then drop everything
            r.kind   = KIND_ERROR;
            r.code   = (length_acc < HEADER_LEN) ? ERR_SHORT_LENGTH : ERR_LONG_LENGTH;
            r.last   = 1'b1;
            emit     = 1'b1;
            rx_phase = PH_HALT;
          end else begin
            body_left = length_acc - HEADER_LEN;
            rx_phase  = PH_HEADER;
          end
        end
      end
      PH_HEADER: begin
        hdr_bytes[byte_cnt] = b;
        if (byte_cnt != HEADER_LAST_INDEX) begin
          byte_cnt++;
        end else begin
          byte_cnt   = '0;
          length_acc = '0;
          emit       = 1'b1;
          if (hdr_bytes[4] != 8'd0) begin
            // bad p_type: report and swallow the body
            r.kind   = KIND_ERROR;
            r.code   = ERR_PROTO_TYPE;
            r.last   = 1'b1;
            rx_phase = (body_left != 0) ? PH_SKIP : PH_LENGTH;
          end else begin
            r.kind         = KIND_HEADER;
            r.sess_id      = {hdr_bytes[0], hdr_bytes[1]};
            r.byte_two     = hdr_bytes[2];
            r.byte_three   = hdr_bytes[3];
            r.session_type = hdr_bytes[5];
            r.system_tag   = {hdr_bytes[6], hdr_bytes[7], hdr_bytes[8], hdr_bytes[9]};
            r.last         = (body_left == 0);
            rx_phase       = (body_left != 0) ? PH_BODY : PH_LENGTH;
          end
        end
      end
      PH_BODY: begin
        body_left   = body_left - 1;
        r.kind      = KIND_BODY;
        r.body_byte = b;
        r.last      = (body_left == 0);
        emit        = 1'b1;
        if (body_left == 0) begin
          rx_phase = PH_LENGTH;
        end
      end
      PH_SKIP: begin
        body_left = body_left - 1;
        if (body_left == 0) begin
          rx_phase = PH_LENGTH;
        end
      end
      default: begin
        // halted: drop the byte
      end
    endcase
    if (emit) begin
      expected_results.push_back(r);
    end
  endtask

  // Track config, check results against the oldest expectation, then predict
  always @(posedge clk) begin : scoreboard
    deframe_result_t got;
    deframe_result_t want;
    if (rst) begin
      rx_phase       = PH_LENGTH;
      byte_cnt       = '0;
      length_acc     = '0;
      body_left      = '0;
      max_length     = MAX_LENGTH_RESET;
      mismatch_count = 0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_length = cfg_data;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind         = m_axis_tuser;
        got.code         = m_axis_tdata[1:0];
        got.sess_id      = m_axis_tdata[17:2];
        got.byte_two     = m_axis_tdata[25:18];
        got.byte_three   = m_axis_tdata[33:26];
        got.session_type = m_axis_tdata[41:34];
        got.system_tag   = m_axis_tdata[73:42];
        got.body_byte    = m_axis_tdata[81:74];
        got.pad          = m_axis_tdata[87:82];
        got.last         = m_axis_tlast;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("[%0t] unexpected result: %s", $time, describe(got));
          end
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("[%0t] result mismatch\n  expected %s\n  actual   %s", $time,
                       describe(want), describe(got));
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        deframe_byte(s_axis_tdata);
      end
    end
    pending_count = expected_results.size();
  end

endmodule

// ===== dv/hsms_frame_deframer_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the HSMS deframer: reset, byte stimulus, handshake pacing and verdict.
module hsms_frame_deframer_unit_tb
  import hfd_pkg::*;
();

  localparam int CYCLE_LIMIT   = 200000;
  localparam int LONG_HOLD     = 80;
  localparam int SETTLE_CYCLES = 8;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [31:0]           cfg_data      = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = '0;   // [7:0] data_byte
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;         // fields as on the block's port
  logic [1:0]            m_axis_tuser;         // [1:0] kind
  logic                  m_axis_tlast;

  int          mismatch_count;
  int          pending_count;
  int          accepted_bytes = 0;
  int          sent_bytes     = 0;
  int          cycle_count    = 0;
  int          src_idle_pct   = 0;
  int          snk_idle_pct   = 0;
  logic [31:0] cur_max        = MAX_LENGTH_RESET;

  hsms_frame_deframer_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  hsms_frame_deframer_unit_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .m_axis_tlast   (m_axis_tlast),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Count cycles and accepted bytes; stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      accepted_bytes <= accepted_bytes + 1;
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("hsms_frame_deframer_unit verification failed");
      $finish;
    end
  end

  // Pace the receiver: random stall bursts plus one long hold-off
  initial begin : sink_pacing
    int gap;
    bit long_hold_done;
    long_hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && accepted_bytes >= 300) begin
        // hold long enough for the queue to fill and the input to back up
        long_hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct) begin
        gap = $urandom_range(1, 12);
        m_axis_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offer one byte, with an optional idle burst first; returns on a falling edge
  task automatic send_byte(input logic [7:0] value);
    int gap;
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent_bytes++;
    @(negedge clk);
  endtask

  task automatic send_length(input logic [31:0] len);
    for (int k = 3; k >= 0; k--) begin
      send_byte(len[8*k +: 8]);
    end
  endtask

  // Header byte 0 sits in the top bits
  task automatic send_header(input logic [79:0] hdr);
    for (int k = 0; k < 10; k++) begin
      send_byte(hdr[79 - 8*k -: 8]);
    end
  endtask

  // Well-formed frame with random content, length within the given maximum
  task automatic send_random_frame(input logic [31:0] limit);
    logic [79:0] hdr;
    logic [31:0] room;
    int unsigned cap;
    int unsigned body_len;
    room = limit - HEADER_LEN;
    cap  = (room > 32'd48) ? 48 : room;
    case ($urandom_range(0, 7))
      0:       body_len = 0;
      1:       body_len = cap;
      default: body_len = $urandom_range(0, (cap < 12) ? cap : 12);
    endcase
    hdr[79:48] = $urandom;
    hdr[47:16] = $urandom;
    hdr[15:0]  = $urandom_range(0, 65535);
    if ($urandom_range(0, 7) == 0) begin
      hdr[47:40] = $urandom_range(1, 255);
    end else begin
      hdr[47:40] = 8'h00;
    end
    send_length(HEADER_LEN + body_len);
    send_header(hdr);
    repeat (body_len) send_byte($urandom_range(0, 255));
  endtask

  // Drop valid and wait until every expected result is out and the pipe is empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_max(input logic [31:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_max = value;
  endtask

  initial begin : stimulus
    logic [31:0] bad_length;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    src_idle_pct = 25;
    snk_idle_pct <= 10;
    @(negedge clk);

    // all-ones header fields with a two-byte body of extreme values
    send_length(HEADER_LEN + 2);
    send_header(80'hFFFF_FFFF_00FF_FFFF_FFFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    // all-zero header except an all-ones protocol type, no body
    send_length(HEADER_LEN);
    send_header(80'h0000_0000_FF00_0000_0000);

    // reset maximum
    while (sent_bytes < 150) send_random_frame(cur_max);

    // maximum at the header size: header-only frames, no idling
    write_max(HEADER_LEN);
    src_idle_pct = 0;
    snk_idle_pct <= 0;
    while (sent_bytes < 260) send_random_frame(cur_max);

    // widest maximum; the long receiver hold lands around here
    write_max(32'hFFFF_FFFF);
    src_idle_pct = 10;
    snk_idle_pct <= 20;
    while (sent_bytes < 520) send_random_frame(cur_max);

    // tight maximum, some frames exactly at the limit
    write_max($urandom_range(10, 40));
    src_idle_pct = 40;
    snk_idle_pct <= 5;
    while (sent_bytes < 760) send_random_frame(cur_max);

    // large random maximum, steady flow to the end
    write_max($urandom | 32'h0000_0040);
    src_idle_pct = 0;
    snk_idle_pct <= 0;
    while (sent_bytes < 900) send_random_frame(cur_max);

    // fatal length: too short, above the maximum, or maximum below the header size
    case ($urandom_range(0, 2))
      0: bad_length = $urandom_range(0, 9);
      1: begin
        write_max($urandom_range(10, 1000));
        bad_length = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : cur_max + 1;
      end
      default: begin
        write_max($urandom_range(0, 9));
        bad_length = $urandom_range(0, 40);
      end
    endcase
    send_length(bad_length);
    // everything after the fatal length is dropped
    repeat (24) send_byte($urandom_range(0, 255));

    settle();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("hsms_frame_deframer_unit verification clean");
    end else begin
      $display("hsms_frame_deframer_unit verification failed");
    end
    $finish;
  end

endmodule
